>>> rtl/arp_cache_resolver_macros.svh
// ----------------------------------------------------------------------------
// ARP cache resolver assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef ARP_CACHE_RESOLVER_MACROS_SVH
`define ARP_CACHE_RESOLVER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define ACR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ARP cache resolver check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define ACR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ARP cache resolver check failed");

`endif

>>> rtl/acr_pkg.sv
// ----------------------------------------------------------------------------
// ARP cache resolver package
// Types, codes and helpers shared by the cache cells and the controller.
// ----------------------------------------------------------------------------
`default_nettype none

package acr_pkg;

	localparam int ENTRIES_DEF = 16;
	localparam int MAX_RES     = 16;

	localparam logic [15:0] OP_REQUEST = 16'd1;
	localparam logic [15:0] OP_REPLY   = 16'd2;

	localparam logic [2:0] REG_MY_IP         = 3'd0;
	localparam logic [2:0] REG_MY_MAC        = 3'd1;
	localparam logic [2:0] REG_RETRY_TIMEOUT = 3'd2;
	localparam logic [2:0] REG_RETRY_COUNT   = 3'd3;
	localparam logic [2:0] REG_CACHE_TIMEOUT = 3'd4;

	typedef enum logic [1:0] {
		CMD_TICK    = 2'd0,
		CMD_RESOLVE = 2'd1,
		CMD_PACKET  = 2'd2,
		CMD_REVERSE = 2'd3
	} acr_cmd_t;

	typedef enum logic [3:0] {
		K_DONE      = 4'd0,
		K_RESOLVED  = 4'd1,
		K_PENDING   = 4'd2,
		K_SEND_REQ  = 4'd3,
		K_SEND_RPL  = 4'd4,
		K_FAILED    = 4'd5,
		K_COMPLETED = 4'd6,
		K_BAD_PKT   = 4'd7,
		K_BAD_OP    = 4'd8,
		K_FULL      = 4'd9,
		K_REV_HIT   = 4'd10,
		K_REV_MISS  = 4'd11,
		K_DROPPED   = 4'd12
	} acr_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TICK,
		ST_SCAN,
		ST_DECIDE,
		ST_EMIT,
		ST_FIN
	} acr_state_t;

	typedef struct packed {
		acr_cmd_t     cmd;
		logic [31:0]  ip_addr;
		logic [47:0]  mac_addr;
		logic [31:0]  target_ip;
		logic [15:0]  opcode;
	} acr_item_t;

	typedef struct packed {
		acr_kind_t    kind;
		logic [31:0]  ip_out;
		logic [47:0]  mac_out;
		logic [31:0]  reply_src_ip;
		logic         last;
	} acr_result_t;

	typedef struct packed {
		logic         valid;
		logic [31:0]  ip;
		logic [47:0]  mac;
		logic         pending;
		logic [7:0]   retries;
		logic [15:0]  timer;
		logic [31:0]  last_update;
	} acr_entry_t;

	function automatic acr_result_t mk_res(acr_kind_t k, logic [31:0] ip,
			logic [47:0] mac, logic [31:0] rsrc);
		acr_result_t r;
		r.kind         = k;
		r.ip_out       = ip;
		r.mac_out      = mac;
		r.reply_src_ip = rsrc;
		r.last         = 1'b0;
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/acr_cell.sv
// ----------------------------------------------------------------------------
// ARP cache cell
// One cache entry that passes its contents to the neighbor cell on a shift.
// ----------------------------------------------------------------------------
`default_nettype none

module acr_cell (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 shift_en,
	input  acr_pkg::acr_entry_t shift_in,
	input  wire                 load_en,
	input  acr_pkg::acr_entry_t load_data,
	output acr_pkg::acr_entry_t data
);

	logic                valid_q;
	acr_pkg::acr_entry_t body_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load_en) begin
			valid_q <= load_data.valid;
		end else if (shift_en) begin
			valid_q <= shift_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_en) begin
			body_q <= load_data;
		end else if (shift_en) begin
			body_q <= shift_in;
		end
	end

	always_comb begin
		data       = body_q;
		data.valid = valid_q;
	end

endmodule

`default_nettype wire

>>> rtl/arp_cache_resolver.sv
// ----------------------------------------------------------------------------
// ARP cache resolver
// ARP cache for one interface, held in a ring of entry cells.
// ----------------------------------------------------------------------------
// The cache entries sit in a ring of cells that rotates once past a single
// head stage for every command. A tick emits its result beats while the ring
// turns and ends with a last beat; a resolve, packet or reverse lookup emits its
// result beats (one or two) after the turn. Busy falls in the cycle that shows
// the last beat, so the next command can be accepted there.
// Result beats appear for one cycle each on result_valid and cannot be held off.
`default_nettype none

module arp_cache_resolver #(
	parameter int ENTRIES = acr_pkg::ENTRIES_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	output logic                 busy,
	input  acr_pkg::acr_item_t   item,
	output logic                 result_valid,
	output acr_pkg::acr_result_t result,
	input  wire                  cfg_we,
	input  wire  [2:0]           cfg_idx,
	input  wire  [47:0]          cfg_data
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int NW = $clog2(ENTRIES + 1);

	acr_pkg::acr_state_t  state_q, state_d;
	logic [IW-1:0]        k_q;
	acr_pkg::acr_item_t   item_q;
	logic [31:0]          time_q;
	logic [31:0]          my_ip_q;
	logic [47:0]          my_mac_q;
	logic [15:0]          rto_q;
	logic [7:0]           rcnt_q;
	logic [31:0]          cto_q;
	logic [NW-1:0]        n_q;
	logic                 hold_v_q;
	acr_pkg::acr_result_t hold_q;
	logic                 m_found_q, m_pend_q, m_fresh_q, f_found_q, r_found_q;
	logic [IW-1:0]        m_idx_q, f_idx_q;
	logic [47:0]          m_mac_q;
	logic [31:0]          r_ip_q;
	acr_pkg::acr_result_t list_q [3];
	logic [1:0]           list_n_q, j_q;
	logic                 res_valid_q;
	acr_pkg::acr_result_t res_q;
	acr_pkg::acr_result_t emit_res, fin_res;

	acr_pkg::acr_entry_t  cells [ENTRIES];
	acr_pkg::acr_entry_t  tail_in;
	logic                 shift_en;
	logic                 accept;
	logic                 k_last;

	acr_pkg::acr_entry_t  head, tick_new;
	logic                 tick_emit, fresh, ip_hit, rev_hit;
	acr_pkg::acr_result_t tick_res;
	logic [15:0]          tt;
	logic [7:0]           r_inc;

	logic                 wr_en;
	logic [IW-1:0]        wr_idx;
	acr_pkg::acr_entry_t  wr_data, start_e, learn_e;
	acr_pkg::acr_result_t lst [3];
	logic [1:0]           lst_n;
	logic                 bad, for_me;

	assign accept   = start && !busy;
	assign busy     = (state_q != acr_pkg::ST_IDLE);
	assign k_last   = (k_q == IW'(ENTRIES - 1));
	assign shift_en = (state_q == acr_pkg::ST_TICK) || (state_q == acr_pkg::ST_SCAN);
	assign tail_in  = (state_q == acr_pkg::ST_TICK) ? tick_new : cells[0];
	assign result_valid = res_valid_q;
	assign result       = res_q;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		acr_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.shift_en  (shift_en),
			.shift_in  ((i == ENTRIES - 1) ? tail_in : cells[(i + 1) % ENTRIES]),
			.load_en   (wr_en && (wr_idx == IW'(i))),
			.load_data (wr_data),
			.data      (cells[i])
		);
	end

	always_comb begin
		head    = cells[0];
		tt      = (rto_q == 16'd0) ? 16'd1 : rto_q;
		fresh   = ((time_q - head.last_update) <= cto_q);
		ip_hit  = head.valid && (head.ip == item_q.ip_addr);
		rev_hit = (item_q.mac_addr != 48'd0) && head.valid &&
			(head.mac == item_q.mac_addr) && fresh;
		r_inc     = head.retries + 8'd1;
		tick_new  = head;
		tick_emit = 1'b0;
		tick_res  = acr_pkg::mk_res(acr_pkg::K_SEND_REQ, head.ip, 48'd0, 32'd0);
		if (head.valid && head.pending) begin
			if (head.timer > 16'd1) begin
				tick_new.timer = head.timer - 16'd1;
			end else if (8'(n_q) >= 8'(acr_pkg::MAX_RES - 1)) begin
				tick_new.timer = 16'd1;
			end else begin
				tick_new.retries = r_inc;
				tick_emit        = 1'b1;
				if (r_inc < rcnt_q) begin
					tick_new.timer = tt;
				end else begin
					tick_res.kind  = acr_pkg::K_FAILED;
					tick_new.valid = 1'b0;
				end
			end
		end
	end

	always_comb begin
		start_e = '{valid: 1'b1, ip: item_q.ip_addr, mac: 48'd0, pending: 1'b1,
			retries: 8'd0, timer: tt, last_update: 32'd0};
		learn_e = '{valid: 1'b1, ip: item_q.ip_addr, mac: item_q.mac_addr,
			pending: 1'b0, retries: 8'd0, timer: 16'd0, last_update: time_q};
		wr_en   = 1'b0;
		wr_idx  = m_idx_q;
		wr_data = start_e;
		for (int i = 0; i < 3; i++) begin
			lst[i] = acr_pkg::mk_res(acr_pkg::K_DONE, 32'd0, 48'd0, 32'd0);
		end
		lst_n  = 2'd0;
		bad    = (item_q.mac_addr == 48'd0) || (item_q.ip_addr == 32'd0);
		for_me = (item_q.target_ip == my_ip_q);
		case (item_q.cmd)
			acr_pkg::CMD_RESOLVE: begin
				if (m_found_q && m_pend_q) begin
					lst[0] = acr_pkg::mk_res(acr_pkg::K_PENDING, item_q.ip_addr, 48'd0, 32'd0);
					lst_n  = 2'd1;
				end else if (m_found_q && m_fresh_q) begin
					lst[0] = acr_pkg::mk_res(acr_pkg::K_RESOLVED, item_q.ip_addr, m_mac_q,
						32'd0);
					lst_n  = 2'd1;
				end else if (m_found_q || f_found_q) begin
					wr_en  = state_q == acr_pkg::ST_DECIDE;
					wr_idx = m_found_q ? m_idx_q : f_idx_q;
					lst[0] = acr_pkg::mk_res(acr_pkg::K_SEND_REQ, item_q.ip_addr, 48'd0, 32'd0);
					lst[1] = acr_pkg::mk_res(acr_pkg::K_PENDING, item_q.ip_addr, 48'd0, 32'd0);
					lst_n  = 2'd2;
				end else begin
					lst[0] = acr_pkg::mk_res(acr_pkg::K_FULL, item_q.ip_addr, 48'd0, 32'd0);
					lst_n  = 2'd1;
				end
			end
			acr_pkg::CMD_PACKET: begin
				wr_data = learn_e;
				if (bad) begin
					lst[0] = acr_pkg::mk_res(acr_pkg::K_BAD_PKT, item_q.ip_addr,
						item_q.mac_addr, 32'd0);
					lst_n  = 2'd1;
				end else begin
					if (m_found_q) begin
						wr_en      = state_q == acr_pkg::ST_DECIDE;
						lst[lst_n] = acr_pkg::mk_res(acr_pkg::K_COMPLETED, item_q.ip_addr,
							item_q.mac_addr, 32'd0);
						lst_n      = lst_n + 2'd1;
					end
					if (for_me) begin
						if (!m_found_q && f_found_q) begin
							wr_en      = state_q == acr_pkg::ST_DECIDE;
							wr_idx     = f_idx_q;
							lst[lst_n] = acr_pkg::mk_res(acr_pkg::K_COMPLETED, item_q.ip_addr,
								item_q.mac_addr, 32'd0);
							lst_n      = lst_n + 2'd1;
						end else if (!m_found_q) begin
							lst[lst_n] = acr_pkg::mk_res(acr_pkg::K_FULL, item_q.ip_addr,
								48'd0, 32'd0);
							lst_n      = lst_n + 2'd1;
						end
						if (item_q.opcode == acr_pkg::OP_REQUEST) begin
							lst[lst_n] = acr_pkg::mk_res(acr_pkg::K_SEND_RPL, item_q.ip_addr,
								item_q.mac_addr, item_q.target_ip);
							lst_n      = lst_n + 2'd1;
						end else if (item_q.opcode != acr_pkg::OP_REPLY) begin
							lst[lst_n] = acr_pkg::mk_res(acr_pkg::K_BAD_OP, item_q.ip_addr,
								48'd0, 32'd0);
							lst_n      = lst_n + 2'd1;
						end
					end else begin
						lst[lst_n] = acr_pkg::mk_res(acr_pkg::K_DROPPED, item_q.ip_addr,
							48'd0, 32'd0);
						lst_n      = lst_n + 2'd1;
					end
				end
			end
			acr_pkg::CMD_REVERSE: begin
				if (r_found_q) begin
					lst[0] = acr_pkg::mk_res(acr_pkg::K_REV_HIT, r_ip_q, item_q.mac_addr, 32'd0);
				end else begin
					lst[0] = acr_pkg::mk_res(acr_pkg::K_REV_MISS, 32'd0, 48'd0, 32'd0);
				end
				lst_n = 2'd1;
			end
			default: begin
				lst_n = 2'd1;
			end
		endcase
	end

	always_comb begin
		emit_res      = list_q[j_q];
		emit_res.last = (j_q == list_n_q - 2'd1);
		fin_res       = hold_v_q ? hold_q :
			acr_pkg::mk_res(acr_pkg::K_DONE, 32'd0, 48'd0, 32'd0);
		fin_res.last  = 1'b1;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			acr_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = (item.cmd == acr_pkg::CMD_TICK) ? acr_pkg::ST_TICK : acr_pkg::ST_SCAN;
				end
			end
			acr_pkg::ST_TICK: begin
				if (k_last) begin
					state_d = acr_pkg::ST_FIN;
				end
			end
			acr_pkg::ST_SCAN: begin
				if (k_last) begin
					state_d = acr_pkg::ST_DECIDE;
				end
			end
			acr_pkg::ST_DECIDE: begin
				state_d = acr_pkg::ST_EMIT;
			end
			acr_pkg::ST_EMIT: begin
				if (j_q == list_n_q - 2'd1) begin
					state_d = acr_pkg::ST_IDLE;
				end
			end
			acr_pkg::ST_FIN: begin
				state_d = acr_pkg::ST_IDLE;
			end
			default: begin
				state_d = acr_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= acr_pkg::ST_IDLE;
			res_valid_q <= 1'b0;
			time_q      <= 32'd0;
			my_ip_q     <= 32'd0;
			my_mac_q    <= 48'd0;
			rto_q       <= 16'd1;
			rcnt_q      <= 8'd3;
			cto_q       <= 32'd120;
			hold_v_q    <= 1'b0;
			k_q         <= '0;
		end else begin
			state_q     <= state_d;
			res_valid_q <= (state_q == acr_pkg::ST_TICK && tick_emit && hold_v_q) ||
				(state_q == acr_pkg::ST_EMIT) || (state_q == acr_pkg::ST_FIN);
			if (cfg_we) begin
				case (cfg_idx)
					acr_pkg::REG_MY_IP:         my_ip_q  <= cfg_data[31:0];
					acr_pkg::REG_MY_MAC:        my_mac_q <= cfg_data;
					acr_pkg::REG_RETRY_TIMEOUT: rto_q    <= cfg_data[15:0];
					acr_pkg::REG_RETRY_COUNT:   rcnt_q   <= cfg_data[7:0];
					acr_pkg::REG_CACHE_TIMEOUT: cto_q    <= cfg_data[31:0];
					default: ;
				endcase
			end
			if (accept) begin
				k_q      <= '0;
				hold_v_q <= 1'b0;
				if (item.cmd == acr_pkg::CMD_TICK) begin
					time_q <= time_q + 32'd1;
				end
			end
			if (shift_en) begin
				k_q <= k_q + IW'(1);
			end
			if (state_q == acr_pkg::ST_TICK && tick_emit) begin
				hold_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q    <= item;
			n_q       <= '0;
			m_found_q <= 1'b0;
			f_found_q <= 1'b0;
			r_found_q <= 1'b0;
		end
		if (state_q == acr_pkg::ST_SCAN) begin
			if (ip_hit && !m_found_q) begin
				m_found_q <= 1'b1;
				m_idx_q   <= k_q;
				m_pend_q  <= head.pending;
				m_fresh_q <= fresh;
				m_mac_q   <= head.mac;
			end
			if (!head.valid && !f_found_q) begin
				f_found_q <= 1'b1;
				f_idx_q   <= k_q;
			end
			if (rev_hit && !r_found_q) begin
				r_found_q <= 1'b1;
				r_ip_q    <= head.ip;
			end
		end
		if (state_q == acr_pkg::ST_TICK && tick_emit) begin
			n_q    <= n_q + NW'(1);
			hold_q <= tick_res;
			res_q  <= hold_q;
		end
		if (state_q == acr_pkg::ST_DECIDE) begin
			list_q   <= lst;
			list_n_q <= lst_n;
			j_q      <= 2'd0;
		end
		if (state_q == acr_pkg::ST_EMIT) begin
			res_q <= emit_res;
			j_q   <= j_q + 2'd1;
		end
		if (state_q == acr_pkg::ST_FIN) begin
			res_q <= fin_res;
		end
	end

	// The interface MAC only sources outgoing frames, which are built outside.
	logic unused_mac;
	assign unused_mac = ^my_mac_q;

endmodule

`default_nettype wire

>>> rtl/acr_checker.sv
// ----------------------------------------------------------------------------
// ARP cache resolver port checker
// Watches the command and result ports of the resolver over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "arp_cache_resolver_macros.svh"

module acr_checker (
	input wire                  clk,
	input wire                  arst_n,
	input wire                  start,
	input wire                  busy,
	input wire                  result_valid,
	input acr_pkg::acr_result_t result
);

	`ACR_ASSERT_NXT(a_start_busy, clk, arst_n, start && !busy, busy)
	`ACR_ASSERT_IMP(a_end_last, clk, arst_n, $fell(busy), result_valid && result.last)
	`ACR_ASSERT_IMP(a_last_idle, clk, arst_n, result_valid && result.last, !busy)
	`ACR_ASSERT_IMP(a_beat_busy, clk, arst_n, result_valid && !result.last, busy)

endmodule

bind arp_cache_resolver acr_checker u_acr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid),
	.result       (result)
);

`default_nettype wire

>>> dv/arp_cache_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ARP cache resolver checker
// Watches the command and result channels, keeps its own copy of the cache
// and configuration, predicts the result beats of every accepted command and
// compares them in order, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_cache_checker (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	input  wire                  busy,
	input  acr_pkg::acr_item_t   item,
	input  wire                  result_valid,
	input  acr_pkg::acr_result_t result,
	input  wire                  cfg_we,
	input  wire  [2:0]           cfg_idx,
	input  wire  [47:0]          cfg_data,
	output int                   errors,
	output int                   pending_beats,
	output int                   beats_seen
);
	import acr_pkg::*;

	localparam int N = 16;

	logic [31:0] c_my_ip;
	logic [15:0] c_rto;
	logic [7:0]  c_rcnt;
	logic [31:0] c_cto;

	logic        e_valid [N];
	logic [31:0] e_ip    [N];
	logic [47:0] e_mac   [N];
	logic        e_pend  [N];
	logic [7:0]  e_tries [N];
	logic [15:0] e_timer [N];
	logic [31:0] e_upd   [N];
	logic [31:0] now;

	acr_result_t beat_queue[$];
	acr_result_t step_out[$];

	assign pending_beats = beat_queue.size();

	task automatic report(input string what);
		errors++;
		$display("%0t checker: %s", $realtime, what);
	endtask

	function automatic void push(acr_kind_t k, logic [31:0] ip, logic [47:0] mac,
			logic [31:0] rsrc);
		acr_result_t r;
		r.kind = k;
		r.ip_out = ip;
		r.mac_out = mac;
		r.reply_src_ip = rsrc;
		r.last = 1'b0;
		if (step_out.size() < MAX_RES)
			step_out.push_back(r);
	endfunction

	function automatic int lookup_ip(logic [31:0] ip);
		for (int i = 0; i < N; i++)
			if (e_valid[i] && e_ip[i] == ip)
				return i;
		return -1;
	endfunction

	function automatic int free_slot();
		for (int i = 0; i < N; i++)
			if (!e_valid[i])
				return i;
		return -1;
	endfunction

	function automatic bit fresh(int i);
		logic [31:0] age;
		age = now - e_upd[i];
		return age <= c_cto;
	endfunction

	function automatic logic [15:0] reload();
		return (c_rto == 0) ? 16'd1 : c_rto;
	endfunction

	function automatic void begin_resolve(int i, logic [31:0] ip);
		e_valid[i] = 1; e_ip[i] = ip; e_mac[i] = 0; e_pend[i] = 1;
		e_tries[i] = 0; e_timer[i] = reload(); e_upd[i] = 0;
	endfunction

	function automatic void learn_entry(int i, logic [31:0] ip, logic [47:0] mac);
		e_valid[i] = 1; e_ip[i] = ip; e_mac[i] = mac; e_pend[i] = 0;
		e_tries[i] = 0; e_timer[i] = 0; e_upd[i] = now;
	endfunction

	function automatic void predict_cache(acr_item_t it);
		int e;
		int hit;
		bit merged;
		acr_result_t r;
		step_out.delete();
		case (it.cmd)
			CMD_TICK: begin
				now = now + 1;
				for (int i = 0; i < N; i++) begin
					if (!e_valid[i] || !e_pend[i])
						continue;
					if (e_timer[i] > 1) begin
						e_timer[i]--;
						continue;
					end
					if (step_out.size() >= MAX_RES - 1) begin
						e_timer[i] = 1;
						continue;
					end
					e_tries[i] = e_tries[i] + 1;
					if (e_tries[i] < c_rcnt) begin
						push(K_SEND_REQ, e_ip[i], 0, 0);
						e_timer[i] = reload();
					end else begin
						push(K_FAILED, e_ip[i], 0, 0);
						e_valid[i] = 0;
					end
				end
			end
			CMD_RESOLVE: begin
				e = lookup_ip(it.ip_addr);
				if (e < 0) begin
					e = free_slot();
					if (e < 0) begin
						push(K_FULL, it.ip_addr, 0, 0);
					end else begin
						begin_resolve(e, it.ip_addr);
						push(K_SEND_REQ, it.ip_addr, 0, 0);
						push(K_PENDING, it.ip_addr, 0, 0);
					end
				end else if (e_pend[e]) begin
					push(K_PENDING, it.ip_addr, 0, 0);
				end else if (fresh(e)) begin
					push(K_RESOLVED, it.ip_addr, e_mac[e], 0);
				end else begin
					begin_resolve(e, it.ip_addr);
					push(K_SEND_REQ, it.ip_addr, 0, 0);
					push(K_PENDING, it.ip_addr, 0, 0);
				end
			end
			CMD_PACKET: begin
				if (it.mac_addr == 0 || it.ip_addr == 0) begin
					push(K_BAD_PKT, it.ip_addr, it.mac_addr, 0);
				end else begin
					merged = 0;
					e = lookup_ip(it.ip_addr);
					if (e >= 0) begin
						learn_entry(e, it.ip_addr, it.mac_addr);
						merged = 1;
						push(K_COMPLETED, it.ip_addr, it.mac_addr, 0);
					end
					if (it.target_ip == c_my_ip) begin
						if (!merged) begin
							e = free_slot();
							if (e < 0) begin
								push(K_FULL, it.ip_addr, 0, 0);
							end else begin
								learn_entry(e, it.ip_addr, it.mac_addr);
								push(K_COMPLETED, it.ip_addr, it.mac_addr, 0);
							end
						end
						if (it.opcode == OP_REQUEST)
							push(K_SEND_RPL, it.ip_addr, it.mac_addr, it.target_ip);
						else if (it.opcode != OP_REPLY)
							push(K_BAD_OP, it.ip_addr, 0, 0);
					end else begin
						push(K_DROPPED, it.ip_addr, 0, 0);
					end
				end
			end
			default: begin
				hit = -1;
				if (it.mac_addr != 0)
					for (int i = 0; i < N && hit < 0; i++)
						if (e_valid[i] && e_mac[i] == it.mac_addr && fresh(i))
							hit = i;
				if (hit >= 0)
					push(K_REV_HIT, e_ip[hit], it.mac_addr, 0);
				else
					push(K_REV_MISS, 0, 0, 0);
			end
		endcase
		if (step_out.size() == 0)
			push(K_DONE, 0, 0, 0);
		step_out[step_out.size() - 1].last = 1'b1;
		foreach (step_out[k]) begin
			r = step_out[k];
			beat_queue.push_back(r);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		acr_result_t exp_r;
		if (!arst_n) begin
			c_my_ip <= 0;
			c_rto <= 1;
			c_rcnt <= 3;
			c_cto <= 120;
			now = 0;
			for (int i = 0; i < N; i++) begin
				e_valid[i] = 0; e_ip[i] = 0; e_mac[i] = 0; e_pend[i] = 0;
				e_tries[i] = 0; e_timer[i] = 0; e_upd[i] = 0;
			end
			beat_queue.delete();
			errors = 0;
			beats_seen = 0;
		end else begin
			if (result_valid) begin
				beats_seen++;
				if (beat_queue.size() == 0) begin
					report($sformatf("unexpected beat kind %0d", result.kind));
				end else begin
					exp_r = beat_queue.pop_front();
					if (result.kind !== exp_r.kind)
						report($sformatf("kind %0d, expected %0d", result.kind, exp_r.kind));
					if (result.ip_out !== exp_r.ip_out)
						report($sformatf("ip_out %h, expected %h", result.ip_out,
							exp_r.ip_out));
					if (result.mac_out !== exp_r.mac_out)
						report($sformatf("mac_out %h, expected %h", result.mac_out,
							exp_r.mac_out));
					if (result.reply_src_ip !== exp_r.reply_src_ip)
						report($sformatf("reply_src_ip %h, expected %h",
							result.reply_src_ip, exp_r.reply_src_ip));
					if (result.last !== exp_r.last)
						report($sformatf("last %b, expected %b", result.last, exp_r.last));
				end
			end
			if (start && !busy)
				predict_cache(item);
			if (cfg_we) begin
				case (cfg_idx)
					REG_MY_IP:         c_my_ip <= cfg_data[31:0];
					REG_RETRY_TIMEOUT: c_rto <= cfg_data[15:0];
					REG_RETRY_COUNT:   c_rcnt <= cfg_data[7:0];
					REG_CACHE_TIMEOUT: c_cto <= cfg_data[31:0];
					default: ;
				endcase
			end
		end
	end

endmodule

`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ARP cache resolver testbench
// Drives directed and random commands with random gaps, rewrites the
// configuration between phases and leaves checking to the checker module.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	import acr_pkg::*;

	localparam int WATCHDOG = 20000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	acr_item_t   item;
	logic        result_valid;
	acr_result_t result;
	logic        cfg_we;
	logic [2:0]  cfg_idx;
	logic [47:0] cfg_data;
	int          errors;
	int          pending_beats;
	int          beats_seen;
	int          idle_cycles = 0;
	int          items_sent;
	int          gap_pct;
	logic [31:0] cur_my_ip;
	logic [31:0] ip_pool [8];
	logic [47:0] mac_pool [8];

	arp_cache_resolver uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.result_valid(result_valid), .result(result),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	arp_cache_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.result_valid(result_valid), .result(result),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.errors(errors), .pending_beats(pending_beats), .beats_seen(beats_seen)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((start && !busy) || result_valid)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	task automatic send_cmd(input acr_item_t it);
		while ($urandom_range(99) < gap_pct)
			@(posedge clk);
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		start <= 1'b0;
		items_sent++;
		@(posedge clk);
	endtask

	task automatic drain();
		while (pending_beats != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic acr_item_t mk_cmd(acr_cmd_t c, logic [31:0] ip, logic [47:0] mac,
			logic [31:0] tgt, logic [15:0] op);
		acr_item_t it;
		it.cmd = c; it.ip_addr = ip; it.mac_addr = mac; it.target_ip = tgt; it.opcode = op;
		return it;
	endfunction

	function automatic logic [47:0] rand48();
		return 48'({$urandom(), $urandom()});
	endfunction

	task automatic random_cmd();
		int pick;
		logic [31:0] ip;
		logic [47:0] mac;
		logic [31:0] tgt;
		logic [15:0] op;
		pick = $urandom_range(99);
		ip = ($urandom_range(9) == 0) ? $urandom() : ip_pool[$urandom_range(7)];
		mac = ($urandom_range(9) == 0) ? rand48() : mac_pool[$urandom_range(7)];
		tgt = ($urandom_range(2) != 0) ? cur_my_ip : $urandom();
		case ($urandom_range(9))
			0:       op = 16'($urandom());
			1, 2:    op = 16'($urandom_range(4));
			3, 4, 5: op = OP_REPLY;
			default: op = OP_REQUEST;
		endcase
		if ($urandom_range(19) == 0) ip = 0;
		if ($urandom_range(19) == 0) mac = 0;
		if (pick < 30)
			send_cmd(mk_cmd(CMD_TICK, $urandom(), rand48(), $urandom(), 16'($urandom())));
		else if (pick < 60)
			send_cmd(mk_cmd(CMD_RESOLVE, ip, rand48(), $urandom(), 16'($urandom())));
		else if (pick < 88)
			send_cmd(mk_cmd(CMD_PACKET, ip, mac, tgt, op));
		else
			send_cmd(mk_cmd(CMD_REVERSE, $urandom(), mac, $urandom(), 16'($urandom())));
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		items_sent = 0;
		gap_pct = 25;
		cur_my_ip = 32'h0a000001;
		for (int i = 0; i < 8; i++) begin
			ip_pool[i] = 32'h0a000010 + i;
			mac_pool[i] = 48'h02_00_00_00_00_10 + i;
		end
		ip_pool[7] = 32'hffffffff;
		mac_pool[7] = 48'hffffffffffff;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(REG_MY_IP, {16'd0, cur_my_ip});
		write_reg(REG_MY_MAC, 48'h02_aa_bb_cc_dd_ee);
		write_reg(REG_RETRY_TIMEOUT, 48'd0);
		write_reg(REG_RETRY_COUNT, 48'd2);
		write_reg(REG_CACHE_TIMEOUT, 48'd3);

		// Directed part: every command, bad packets, opcodes, staleness, full table.
		send_cmd(mk_cmd(CMD_RESOLVE, 32'h0a000010, 0, 0, 0));
		send_cmd(mk_cmd(CMD_RESOLVE, 32'h0a000010, 0, 0, 0));
		send_cmd(mk_cmd(CMD_TICK, 0, 0, 0, 0));
		send_cmd(mk_cmd(CMD_TICK, 0, 0, 0, 0));
		send_cmd(mk_cmd(CMD_PACKET, 32'h0a000011, 0, cur_my_ip, OP_REQUEST));
		send_cmd(mk_cmd(CMD_PACKET, 0, 48'h1, cur_my_ip, OP_REQUEST));
		send_cmd(mk_cmd(CMD_PACKET, 32'h0a000011, 48'h02_00_00_00_00_11, cur_my_ip,
			OP_REQUEST));
		send_cmd(mk_cmd(CMD_PACKET, 32'h0a000012, 48'hffffffffffff, cur_my_ip, OP_REPLY));
		send_cmd(mk_cmd(CMD_PACKET, 32'hffffffff, 48'h02_00_00_00_00_13, cur_my_ip,
			16'd3));
		send_cmd(mk_cmd(CMD_PACKET, 32'h0a000014, 48'h02_00_00_00_00_14, cur_my_ip,
			16'hffff));
		send_cmd(mk_cmd(CMD_PACKET, 32'h0a000011, 48'h02_00_00_00_00_15, 32'h0, 16'd4));
		send_cmd(mk_cmd(CMD_RESOLVE, 32'h0a000011, 0, 0, 0));
		send_cmd(mk_cmd(CMD_REVERSE, 0, 48'h02_00_00_00_00_15, 0, 0));
		send_cmd(mk_cmd(CMD_REVERSE, 0, 48'h0, 0, 0));
		send_cmd(mk_cmd(CMD_REVERSE, 0, 48'h02_00_00_00_77_77, 0, 0));
		repeat (4) send_cmd(mk_cmd(CMD_TICK, 0, 0, 0, 0));
		send_cmd(mk_cmd(CMD_RESOLVE, 32'h0a000011, 0, 0, 0));
		for (int i = 0; i < 17; i++)
			send_cmd(mk_cmd(CMD_RESOLVE, 32'h0b000000 + i, 0, 0, 0));
		send_cmd(mk_cmd(CMD_PACKET, 32'h0c000001, 48'h3, cur_my_ip, OP_REQUEST));
		repeat (3) send_cmd(mk_cmd(CMD_TICK, 0, 0, 0, 0));
		drain();

		// Random phases, each under a different configuration.
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin
					cur_my_ip = 32'hffffffff;
					write_reg(REG_MY_IP, {16'd0, cur_my_ip});
					write_reg(REG_MY_MAC, 48'hffffffffffff);
					write_reg(REG_RETRY_TIMEOUT, 48'd1);
					write_reg(REG_RETRY_COUNT, 48'd255);
					write_reg(REG_CACHE_TIMEOUT, 48'hffffffff);
				end
				1: begin
					cur_my_ip = 32'h0;
					write_reg(REG_MY_IP, 48'd0);
					write_reg(REG_MY_MAC, 48'd0);
					write_reg(REG_RETRY_TIMEOUT, 48'd3);
					write_reg(REG_RETRY_COUNT, 48'd1);
					write_reg(REG_CACHE_TIMEOUT, 48'd0);
				end
				2: begin
					cur_my_ip = $urandom();
					write_reg(REG_MY_IP, {16'd0, cur_my_ip});
					write_reg(REG_RETRY_TIMEOUT, 48'hffff);
					write_reg(REG_CACHE_TIMEOUT, 48'd5);
					gap_pct = 0;
				end
				3: begin
					write_reg(REG_RETRY_TIMEOUT, 48'd2);
					write_reg(REG_RETRY_COUNT, 48'd4);
					gap_pct = 25;
				end
				default: begin
					cur_my_ip = 32'h0a000001;
					write_reg(REG_MY_IP, {16'd0, cur_my_ip});
					write_reg(REG_RETRY_TIMEOUT, 48'd1);
					write_reg(REG_RETRY_COUNT, 48'd3);
					write_reg(REG_CACHE_TIMEOUT, 48'd120);
				end
			endcase
			for (int n = 0; n < 52; n++)
				random_cmd();
			drain();
		end

		$display("tb: %0d commands sent, %0d result beats checked over directed and",
			items_sent, beats_seen);
		$display("tb: five random configuration phases");
		if (errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+rtl
rtl/acr_pkg.sv
rtl/acr_cell.sv
rtl/arp_cache_resolver.sv
rtl/acr_checker.sv
dv/arp_cache_checker.sv
dv/tb.sv
